### rtl/multi_policy_ready_queue_scheduler_assert.svh
// assertion macros for the ready-queue scheduler
// used by multi_policy_ready_queue_scheduler.sv, no other dependencies
`ifndef MULTI_POLICY_READY_QUEUE_SCHEDULER_ASSERT_SVH
`define MULTI_POLICY_READY_QUEUE_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define MPQS_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("mpqs assertion failed");

// next-cycle implication
`define MPQS_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("mpqs assertion failed");

`endif

### rtl/mpqs_pkg.sv
// constants, types and codes of the ready-queue scheduler
// no dependencies
package mpqs_pkg;

  localparam int DEPTH         = 16;
  localparam int TICKET_BITS   = 8;
  localparam int PRIORITY_BITS = 8;

  localparam int IDX_BITS      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS      = $clog2(DEPTH + 1);
  localparam int TOTAL_BITS    = 12;
  localparam int DRAW_BITS     = 16;
  localparam int DCNT_BITS     = $clog2(DRAW_BITS);
  localparam int SUM_BITS      = TICKET_BITS + IDX_BITS;
  localparam int CMP_A         = (SUM_BITS > TOTAL_BITS + 1) ? SUM_BITS : TOTAL_BITS + 1;
  localparam int CMP_BITS      = (CMP_A > PRIORITY_BITS) ? CMP_A : PRIORITY_BITS;

  typedef logic [IDX_BITS-1:0]      idx_t;
  typedef logic [CNT_BITS-1:0]      cnt_t;
  typedef logic [TICKET_BITS-1:0]   ticket_t;
  typedef logic [PRIORITY_BITS-1:0] prio_t;
  typedef logic [TOTAL_BITS-1:0]    total_t;
  typedef logic [DRAW_BITS-1:0]     draw_t;
  typedef logic [DCNT_BITS-1:0]     dcnt_t;
  typedef logic [SUM_BITS-1:0]      sum_t;
  typedef logic [CMP_BITS-1:0]      cmp_t;

  typedef struct packed {
    logic [7:0] id;
    logic [1:0] policy;
    ticket_t    tickets;
    prio_t      prio;
  } entry_t;

  // thread and pick policies
  localparam logic [1:0] POL_RR  = 2'd0;
  localparam logic [1:0] POL_LOT = 2'd1;
  localparam logic [1:0] POL_RT  = 2'd2;

  // commands
  localparam logic CMD_ENQ  = 1'b0;
  localparam logic CMD_PICK = 1'b1;

  // result status
  localparam logic [1:0] STAT_ENQ   = 2'd0;
  localparam logic [1:0] STAT_PICK  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;
  localparam logic [1:0] STAT_FULL  = 2'd3;

endpackage

### rtl/multi_policy_ready_queue_scheduler.sv
// ready-table thread scheduler with round robin, lottery and real-time pick
// depends on mpqs_pkg and multi_policy_ready_queue_scheduler_assert.svh
//
// usage: one input channel (in_valid/in_ready) carries a command, either an
// enqueue of a thread entry or a pick of the next thread by running_policy.
// every item gives exactly one result on out_valid/out_ready: a status,
// the picked id (zero unless picked) and the lottery ticket total afterwards.
// the block takes one item at a time; in_ready is high only while idle.
// an enqueue, full or empty result and a round robin pick need no walk; a
// real-time pick walks the table (one entry per cycle through the walk); a
// lottery pick runs the restoring modulo (one draw bit per cycle) and the
// ticket walk, both on one shared subtract/compare unit.
// results sit in an output register, so the next item is taken while a
// result still waits; a stalled receiver holds the block only when a new
// result is ready to be written.
// reset (synchronous, rst_n low) empties the table and clears the total;
// table contents are not cleared, only entries below the count are read.
`include "multi_policy_ready_queue_scheduler_assert.svh"

module multi_policy_ready_queue_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [7:0]  in_thread_id,
  input  logic [1:0]  in_thread_policy,
  input  logic [7:0]  in_thread_tickets,
  input  logic [7:0]  in_thread_priority,
  input  logic [1:0]  in_running_policy,
  input  logic [15:0] in_random_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [7:0]  out_picked_id,
  output logic [11:0] out_ticket_total
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DIV    = 3'd1;
  localparam logic [2:0] S_WALK   = 3'd2;
  localparam logic [2:0] S_REMOVE = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;

  logic [2:0] state_r, state_nxt;

  mpqs_pkg::entry_t slots_r   [mpqs_pkg::DEPTH];
  mpqs_pkg::entry_t slots_nxt [mpqs_pkg::DEPTH];

  mpqs_pkg::cnt_t   count_r, count_nxt;
  mpqs_pkg::total_t total_r, total_nxt;
  mpqs_pkg::idx_t   idx_r, idx_nxt;
  mpqs_pkg::idx_t   k_r, k_nxt;
  mpqs_pkg::sum_t   sum_r, sum_nxt;
  mpqs_pkg::total_t rem_r, rem_nxt;
  mpqs_pkg::draw_t  draw_r, draw_nxt;
  mpqs_pkg::dcnt_t  dcnt_r, dcnt_nxt;
  mpqs_pkg::prio_t  best_prio_r, best_prio_nxt;
  logic             is_lot_r, is_lot_nxt;
  logic [1:0]       res_status_r, res_status_nxt;
  logic [7:0]       res_id_r, res_id_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [7:0]       out_id_r, out_id_nxt;
  mpqs_pkg::total_t out_total_r, out_total_nxt;

  // shared subtract/compare unit
  mpqs_pkg::cmp_t   alu_a, alu_b, alu_diff;
  logic             alu_lt;

  mpqs_pkg::idx_t   rd_addr;
  mpqs_pkg::entry_t rd_entry;
  mpqs_pkg::entry_t new_entry;
  mpqs_pkg::sum_t   sum_add;
  logic [mpqs_pkg::TOTAL_BITS:0] div_r;
  logic             walk_last;

  assign alu_lt   = (alu_a < alu_b);
  assign alu_diff = alu_a - alu_b;

  assign rd_addr  = (state_r == S_REMOVE) ? k_r : idx_r;
  assign rd_entry = slots_r[rd_addr];
  assign sum_add  = sum_r + mpqs_pkg::sum_t'(rd_entry.tickets);
  assign div_r    = {rem_r, draw_r[mpqs_pkg::DRAW_BITS-1]};
  assign walk_last = (mpqs_pkg::cnt_t'(idx_r) == count_r - mpqs_pkg::cnt_t'(1));

  assign new_entry.id      = in_thread_id;
  assign new_entry.policy  = in_thread_policy;
  assign new_entry.tickets = mpqs_pkg::ticket_t'(in_thread_tickets);
  assign new_entry.prio    = mpqs_pkg::prio_t'(in_thread_priority);

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_picked_id    = out_id_r;
  assign out_ticket_total = out_total_r;

  always_comb begin
    state_nxt      = state_r;
    slots_nxt      = slots_r;
    count_nxt      = count_r;
    total_nxt      = total_r;
    idx_nxt        = idx_r;
    k_nxt          = k_r;
    sum_nxt        = sum_r;
    rem_nxt        = rem_r;
    draw_nxt       = draw_r;
    dcnt_nxt       = dcnt_r;
    best_prio_nxt  = best_prio_r;
    is_lot_nxt     = is_lot_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_total_nxt  = out_total_r;
    alu_a          = '0;
    alu_b          = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_id_nxt = '0;
          if (in_cmd == mpqs_pkg::CMD_ENQ) begin
            if (count_r < mpqs_pkg::cnt_t'(mpqs_pkg::DEPTH)) begin
              slots_nxt[count_r[mpqs_pkg::IDX_BITS-1:0]] = new_entry;
              if (new_entry.policy == mpqs_pkg::POL_LOT) begin
                total_nxt = total_r + mpqs_pkg::total_t'(new_entry.tickets);
              end
              count_nxt      = count_r + mpqs_pkg::cnt_t'(1);
              res_status_nxt = mpqs_pkg::STAT_ENQ;
            end else begin
              res_status_nxt = mpqs_pkg::STAT_FULL;
            end
            state_nxt = S_FIN;
          end else if (count_r == '0) begin
            res_status_nxt = mpqs_pkg::STAT_EMPTY;
            state_nxt      = S_FIN;
          end else begin
            k_nxt      = '0;
            is_lot_nxt = (in_running_policy == mpqs_pkg::POL_LOT);
            draw_nxt   = in_random_word;
            rem_nxt    = '0;
            dcnt_nxt   = mpqs_pkg::dcnt_t'(mpqs_pkg::DRAW_BITS - 1);
            if (in_running_policy == mpqs_pkg::POL_LOT && total_r != '0) begin
              state_nxt = S_DIV;
            end else if (in_running_policy == mpqs_pkg::POL_RT &&
                         count_r != mpqs_pkg::cnt_t'(1)) begin
              // head is the first candidate, walk the rest
              best_prio_nxt = slots_r[0].prio;
              idx_nxt       = mpqs_pkg::idx_t'(1);
              state_nxt     = S_WALK;
            end else begin
              state_nxt = S_REMOVE;
            end
          end
        end
      end

      S_DIV: begin
        // one restoring step per draw bit
        alu_a    = mpqs_pkg::cmp_t'(div_r);
        alu_b    = mpqs_pkg::cmp_t'(total_r);
        rem_nxt  = alu_lt ? div_r[mpqs_pkg::TOTAL_BITS-1:0]
                          : alu_diff[mpqs_pkg::TOTAL_BITS-1:0];
        draw_nxt = draw_r << 1;
        if (dcnt_r == '0) begin
          idx_nxt   = '0;
          sum_nxt   = '0;
          state_nxt = S_WALK;
        end else begin
          dcnt_nxt = dcnt_r - mpqs_pkg::dcnt_t'(1);
        end
      end

      S_WALK: begin
        if (is_lot_r) begin
          alu_a = mpqs_pkg::cmp_t'(rem_r);
          alu_b = mpqs_pkg::cmp_t'(sum_add);
          if (rd_entry.policy == mpqs_pkg::POL_LOT) begin
            sum_nxt = sum_add;
          end
          if (rd_entry.policy == mpqs_pkg::POL_LOT && alu_lt) begin
            k_nxt     = idx_r;
            state_nxt = S_REMOVE;
          end else if (walk_last) begin
            // no winner after a wrapped total: head
            state_nxt = S_REMOVE;
          end else begin
            idx_nxt = idx_r + mpqs_pkg::idx_t'(1);
          end
        end else begin
          alu_a = mpqs_pkg::cmp_t'(best_prio_r);
          alu_b = mpqs_pkg::cmp_t'(rd_entry.prio);
          if (rd_entry.policy == mpqs_pkg::POL_RT && alu_lt) begin
            best_prio_nxt = rd_entry.prio;
            k_nxt         = idx_r;
          end
          if (walk_last) begin
            state_nxt = S_REMOVE;
          end else begin
            idx_nxt = idx_r + mpqs_pkg::idx_t'(1);
          end
        end
      end

      S_REMOVE: begin
        res_id_nxt     = rd_entry.id;
        res_status_nxt = mpqs_pkg::STAT_PICK;
        if (rd_entry.policy == mpqs_pkg::POL_LOT) begin
          total_nxt = total_r - mpqs_pkg::total_t'(rd_entry.tickets);
        end
        // close the gap, order kept
        for (int i = 0; i < mpqs_pkg::DEPTH - 1; i++) begin
          if (mpqs_pkg::idx_t'(i) >= k_r) begin
            slots_nxt[i] = slots_r[i+1];
          end
        end
        count_nxt = count_r - mpqs_pkg::cnt_t'(1);
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt     = res_id_r;
          out_total_nxt  = total_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slots_r      <= slots_nxt;
    idx_r        <= idx_nxt;
    k_r          <= k_nxt;
    sum_r        <= sum_nxt;
    rem_r        <= rem_nxt;
    draw_r       <= draw_nxt;
    dcnt_r       <= dcnt_nxt;
    best_prio_r  <= best_prio_nxt;
    is_lot_r     <= is_lot_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_total_r  <= out_total_nxt;
  end

  `MPQS_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= mpqs_pkg::cnt_t'(mpqs_pkg::DEPTH))
  `MPQS_ASSERT_NXT(a_full_no_change, clk, rst_n, in_valid && in_ready && in_cmd == mpqs_pkg::CMD_ENQ && count_r == mpqs_pkg::cnt_t'(mpqs_pkg::DEPTH), state_r == S_FIN && res_status_r == mpqs_pkg::STAT_FULL && $stable(count_r))
  `MPQS_ASSERT_NXT(a_remove_dec, clk, rst_n, state_r == S_REMOVE, count_r == $past(count_r) - mpqs_pkg::cnt_t'(1) && state_r == S_FIN)
  `MPQS_ASSERT_IMP(a_id_zero, clk, rst_n, out_valid && out_status != mpqs_pkg::STAT_PICK, out_picked_id == 8'd0)

endmodule
